// ----- hdl/tadm_pkg.sv -----
`timescale 1ns / 1ps

package tadm_pkg;

  // Field widths
  localparam int unsigned AXIS_W = 16;   // Q1.14 signed axes
  localparam int unsigned REG_W  = 15;   // configuration registers
  localparam int unsigned TRIG_W = 15;   // Q1.14 unsigned triggers
  localparam int unsigned RPS_W  = 16;   // Q8.8 signed velocities
  localparam int unsigned MIX_W  = AXIS_W + 1;      // y - x, y + x magnitudes
  localparam int unsigned NUM_W  = MIX_W + REG_W;   // |v| * speed
  localparam int unsigned QUO_W  = REG_W;           // quotient never exceeds speed

  // Arcade mix divider
  localparam int unsigned DIV_STEPS = QUO_W;
  localparam int unsigned CNT_W     = $clog2(DIV_STEPS + 1);

  // Decoupling queue between front and back
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [MIX_W-1:0] ONE_Q14 = MIX_W'(16384);

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DRIVE_LOW    = 3'd0,
    CFG_DRIVE_MED    = 3'd1,
    CFG_DRIVE_HIGH   = 3'd2,
    CFG_DRIVE_DZ     = 3'd3,
    CFG_STICK_DZ     = 3'd4,
    CFG_TRENCHER_MAX = 3'd5,
    CFG_HOPPER_MAX   = 3'd6
  } cfg_idx_e;

  // Reset values
  localparam logic [REG_W-1:0] RST_DRIVE_LOW    = REG_W'(128);
  localparam logic [REG_W-1:0] RST_DRIVE_MED    = REG_W'(256);
  localparam logic [REG_W-1:0] RST_DRIVE_HIGH   = REG_W'(512);
  localparam logic [REG_W-1:0] RST_DRIVE_DZ     = REG_W'(1638);
  localparam logic [REG_W-1:0] RST_STICK_DZ     = REG_W'(1638);
  localparam logic [REG_W-1:0] RST_TRENCHER_MAX = REG_W'(256);
  localparam logic [REG_W-1:0] RST_HOPPER_MAX   = REG_W'(256);

  // Track speed selection
  typedef enum logic [1:0] {
    SPEED_LOW  = 2'd0,
    SPEED_MED  = 2'd1,
    SPEED_HIGH = 2'd2
  } speed_e;

  typedef struct packed {
    logic [REG_W-1:0] drive_low_rps;
    logic [REG_W-1:0] drive_med_rps;
    logic [REG_W-1:0] drive_high_rps;
    logic [REG_W-1:0] drive_deadzone;
    logic [REG_W-1:0] stick_deadzone;
    logic [REG_W-1:0] trencher_max_rps;
    logic [REG_W-1:0] hopper_belt_max_rps;
  } tadm_cfg_t;

  // Classified request handed from front to back
  typedef struct packed {
    logic [NUM_W-1:0]  l_num;
    logic [NUM_W-1:0]  r_num;
    logic [MIX_W-1:0]  m;
    logic              l_neg;
    logic              r_neg;
    logic [RPS_W-1:0]  trencher_rps;
    logic [RPS_W-1:0]  hopper_belt_rps;
    logic [AXIS_W-1:0] hopper_act_percent;
    logic              disabled;
  } tadm_cmd_t;

endpackage

// ----- hdl/tadm_in_if.sv -----
`timescale 1ns / 1ps

interface tadm_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [tadm_pkg::AXIS_W-1:0] drive_x;
  logic signed [tadm_pkg::AXIS_W-1:0] drive_y;
  logic        [tadm_pkg::TRIG_W-1:0] trencher_trigger;
  logic                              trencher_invert;
  logic        [tadm_pkg::TRIG_W-1:0] hopper_trigger;
  logic                              hopper_invert;
  logic signed [tadm_pkg::AXIS_W-1:0] hopper_act_axis;
  logic                              hopper_below_zero;
  logic                              speed_low_btn;
  logic                              speed_med_btn;
  logic                              speed_high_btn;
  logic                              disable_btn;

  modport source (
    output valid, drive_x, drive_y, trencher_trigger, trencher_invert, hopper_trigger,
           hopper_invert, hopper_act_axis, hopper_below_zero, speed_low_btn,
           speed_med_btn, speed_high_btn, disable_btn,
    input  ready
  );

  modport sink (
    input  valid, drive_x, drive_y, trencher_trigger, trencher_invert, hopper_trigger,
           hopper_invert, hopper_act_axis, hopper_below_zero, speed_low_btn,
           speed_med_btn, speed_high_btn, disable_btn,
    output ready
  );
endinterface

// ----- hdl/tadm_out_if.sv -----
`timescale 1ns / 1ps

interface tadm_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [tadm_pkg::RPS_W-1:0]  left_track_rps;
  logic signed [tadm_pkg::RPS_W-1:0]  right_track_rps;
  logic signed [tadm_pkg::RPS_W-1:0]  trencher_rps;
  logic signed [tadm_pkg::RPS_W-1:0]  hopper_belt_rps;
  logic signed [tadm_pkg::AXIS_W-1:0] hopper_act_percent;
  logic                              disabled;

  modport source (
    output valid, left_track_rps, right_track_rps, trencher_rps, hopper_belt_rps,
           hopper_act_percent, disabled,
    input  ready
  );

  modport sink (
    input  valid, left_track_rps, right_track_rps, trencher_rps, hopper_belt_rps,
           hopper_act_percent, disabled,
    output ready
  );
endinterface

// ----- hdl/tadm_front.sv -----
`timescale 1ns / 1ps

module tadm_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tadm_pkg::tadm_cfg_t cfg_i,
  tadm_in_if.sink             joy_i,
  output logic                push_o,
  output tadm_pkg::tadm_cmd_t cmd_o,
  input  logic                full_i
);

  // Products captured at accept time
  typedef struct packed {
    logic [2*tadm_pkg::AXIS_W-2:0]        xx;
    logic [2*tadm_pkg::AXIS_W-2:0]        yy;
    logic [2*tadm_pkg::REG_W-1:0]         dd;
    logic [tadm_pkg::NUM_W-1:0]           l_num;
    logic [tadm_pkg::NUM_W-1:0]           r_num;
    logic [tadm_pkg::MIX_W-1:0]           m;
    logic                                 l_neg;
    logic                                 r_neg;
    logic [tadm_pkg::TRIG_W+tadm_pkg::REG_W-1:0] trp;
    logic [tadm_pkg::TRIG_W+tadm_pkg::REG_W-1:0] hbp;
    logic                                 tinv;
    logic                                 hinv;
    logic [tadm_pkg::AXIS_W-1:0]          act;
    logic                                 below_zero;
    logic                                 dis;
  } tadm_s1_t;

  logic                        s1_valid_q;
  tadm_s1_t                    s1_q, s1_d;
  tadm_pkg::speed_e            level_q, level_d;
  logic [2:0]                  prev_btn_q;
  logic [2:0]                  btns, rise;
  logic                        accept;
  logic [tadm_pkg::REG_W-1:0]  speed;
  logic [tadm_pkg::MIX_W-1:0]  x_ext, y_ext, l, r, l_mag, r_mag, m_lr;
  logic [tadm_pkg::AXIS_W-1:0] x_mag, y_mag;

  // Belt velocity: trigger * max >> 14, saturated, then signed
  function automatic logic [tadm_pkg::RPS_W-1:0] belt_vel(
    input logic [tadm_pkg::TRIG_W+tadm_pkg::REG_W-1:0] p,
    input logic                                       inv
  );
    logic [tadm_pkg::RPS_W-2:0] q;
    q = p[tadm_pkg::TRIG_W+tadm_pkg::REG_W-1] ? '1
                                               : p[tadm_pkg::TRIG_W+tadm_pkg::REG_W-2:14];
    return inv ? (tadm_pkg::RPS_W'(0) - {1'b0, q}) : {1'b0, q};
  endfunction

  assign joy_i.ready = !s1_valid_q || !full_i;
  assign accept      = joy_i.valid && joy_i.ready;
  assign push_o      = s1_valid_q && !full_i;

  // Speed buttons: rising edge selects level, highest wins
  always_comb begin
    btns    = {joy_i.speed_high_btn, joy_i.speed_med_btn, joy_i.speed_low_btn};
    rise    = btns & ~prev_btn_q;
    level_d = level_q;
    if (rise[2]) begin
      level_d = tadm_pkg::SPEED_HIGH;
    end else if (rise[1]) begin
      level_d = tadm_pkg::SPEED_MED;
    end else if (rise[0]) begin
      level_d = tadm_pkg::SPEED_LOW;
    end
    case (level_d)
      tadm_pkg::SPEED_LOW:  speed = cfg_i.drive_low_rps;
      tadm_pkg::SPEED_HIGH: speed = cfg_i.drive_high_rps;
      default:              speed = cfg_i.drive_med_rps;
    endcase
  end

  // Mixing terms and products
  always_comb begin
    x_ext = {joy_i.drive_x[tadm_pkg::AXIS_W-1], joy_i.drive_x};
    y_ext = {joy_i.drive_y[tadm_pkg::AXIS_W-1], joy_i.drive_y};
    l     = y_ext - x_ext;
    r     = y_ext + x_ext;
    l_mag = l[tadm_pkg::MIX_W-1] ? (~l + 1'b1) : l;
    r_mag = r[tadm_pkg::MIX_W-1] ? (~r + 1'b1) : r;
    x_mag = joy_i.drive_x[tadm_pkg::AXIS_W-1] ? (~joy_i.drive_x + 1'b1) : joy_i.drive_x;
    y_mag = joy_i.drive_y[tadm_pkg::AXIS_W-1] ? (~joy_i.drive_y + 1'b1) : joy_i.drive_y;
    m_lr  = (l_mag > r_mag) ? l_mag : r_mag;

    s1_d.xx         = (2*tadm_pkg::AXIS_W-1)'(x_mag * x_mag);
    s1_d.yy         = (2*tadm_pkg::AXIS_W-1)'(y_mag * y_mag);
    s1_d.dd         = (2*tadm_pkg::REG_W)'(cfg_i.drive_deadzone * cfg_i.drive_deadzone);
    s1_d.l_num      = tadm_pkg::NUM_W'(l_mag * speed);
    s1_d.r_num      = tadm_pkg::NUM_W'(r_mag * speed);
    s1_d.m          = (m_lr > tadm_pkg::ONE_Q14) ? m_lr : tadm_pkg::ONE_Q14;
    s1_d.l_neg      = l[tadm_pkg::MIX_W-1];
    s1_d.r_neg      = r[tadm_pkg::MIX_W-1];
    s1_d.trp        = (tadm_pkg::TRIG_W+tadm_pkg::REG_W)'(joy_i.trencher_trigger *
                                                           cfg_i.trencher_max_rps);
    s1_d.hbp        = (tadm_pkg::TRIG_W+tadm_pkg::REG_W)'(joy_i.hopper_trigger *
                                                           cfg_i.hopper_belt_max_rps);
    s1_d.tinv       = joy_i.trencher_invert;
    s1_d.hinv       = joy_i.hopper_invert;
    s1_d.act        = joy_i.hopper_act_axis;
    s1_d.below_zero = joy_i.hopper_below_zero;
    s1_d.dis        = joy_i.disable_btn;
  end

  // Classify: deadzone, disable, belts, actuator
  logic [2*tadm_pkg::AXIS_W-1:0] m2;
  logic                          zero_tracks;
  logic [tadm_pkg::AXIS_W-1:0]   act_mag;
  logic                          act_zero;

  always_comb begin
    m2          = {1'b0, s1_q.xx} + {1'b0, s1_q.yy};
    zero_tracks = s1_q.dis || (m2 < {2'b0, s1_q.dd});
    act_mag     = s1_q.act[tadm_pkg::AXIS_W-1] ? (~s1_q.act + 1'b1) : s1_q.act;
    act_zero    = (act_mag < {1'b0, cfg_i.stick_deadzone}) ||
                  (s1_q.below_zero && s1_q.act[tadm_pkg::AXIS_W-1]);

    cmd_o.l_num              = zero_tracks ? '0 : s1_q.l_num;
    cmd_o.r_num              = zero_tracks ? '0 : s1_q.r_num;
    cmd_o.m                  = zero_tracks ? tadm_pkg::ONE_Q14 : s1_q.m;
    cmd_o.l_neg              = s1_q.l_neg;
    cmd_o.r_neg              = s1_q.r_neg;
    cmd_o.trencher_rps       = s1_q.dis ? '0 : belt_vel(s1_q.trp, s1_q.tinv);
    cmd_o.hopper_belt_rps    = s1_q.dis ? '0 : belt_vel(s1_q.hbp, s1_q.hinv);
    cmd_o.hopper_act_percent = (s1_q.dis || act_zero) ? '0 : s1_q.act;
    cmd_o.disabled           = s1_q.dis;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      level_q    <= tadm_pkg::SPEED_MED;
      prev_btn_q <= '0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
        level_q    <= level_d;
        prev_btn_q <= btns;
      end else if (push_o) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  // Stage payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= s1_d;
    end
  end

endmodule

// ----- hdl/tadm_fifo.sv -----
`timescale 1ns / 1ps

module tadm_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  tadm_pkg::tadm_cmd_t data_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                valid_o,
  output tadm_pkg::tadm_cmd_t data_o
);

  tadm_pkg::tadm_cmd_t           mem_q [tadm_pkg::QDEPTH];
  logic [tadm_pkg::QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [tadm_pkg::QCNT_W-1:0]   cnt_q;
  logic                          do_push, do_pop;

  assign full_o  = (cnt_q == tadm_pkg::QCNT_W'(tadm_pkg::QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == tadm_pkg::QPTR_W'(tadm_pkg::QDEPTH - 1)) ? '0
                                                                      : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == tadm_pkg::QPTR_W'(tadm_pkg::QDEPTH - 1)) ? '0
                                                                      : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ----- hdl/tadm_back.sv -----
`timescale 1ns / 1ps

module tadm_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  tadm_pkg::tadm_cmd_t cmd_i,
  output logic                pop_o,
  tadm_out_if.source          cmd_o
);

  typedef enum logic {
    ST_IDLE,
    ST_DIV
  } state_e;

  state_e                        state_q;
  logic [tadm_pkg::CNT_W-1:0]    cnt_q;
  logic [tadm_pkg::MIX_W-1:0]    m_q;
  logic [tadm_pkg::MIX_W-1:0]    rem_l_q, rem_r_q, rem_l_d, rem_r_d;
  logic [tadm_pkg::QUO_W-1:0]    sh_l_q, sh_r_q, sh_l_d, sh_r_d;
  logic                          l_neg_q, r_neg_q;
  logic [tadm_pkg::RPS_W-1:0]    tr_q, hb_q;
  logic [tadm_pkg::AXIS_W-1:0]   ha_q;
  logic                          dis_q;
  logic                          out_valid_q;
  logic [tadm_pkg::RPS_W-1:0]    lt_q, rt_q, otr_q, ohb_q;
  logic [tadm_pkg::AXIS_W-1:0]   oha_q;
  logic                          odis_q;
  logic                          out_free;
  logic                          post;
  logic [tadm_pkg::MIX_W:0]      t_l, t_r;
  logic                          ge_l, ge_r;

  assign out_free = !out_valid_q || cmd_o.ready;
  assign pop_o    = (state_q == ST_IDLE) && valid_i;
  assign post     = (state_q == ST_DIV) && (cnt_q == '0) && out_free;

  // One restoring step on each track
  always_comb begin
    t_l     = {rem_l_q, sh_l_q[tadm_pkg::QUO_W-1]};
    t_r     = {rem_r_q, sh_r_q[tadm_pkg::QUO_W-1]};
    ge_l    = t_l >= {1'b0, m_q};
    ge_r    = t_r >= {1'b0, m_q};
    rem_l_d = ge_l ? tadm_pkg::MIX_W'(t_l - {1'b0, m_q}) : t_l[tadm_pkg::MIX_W-1:0];
    rem_r_d = ge_r ? tadm_pkg::MIX_W'(t_r - {1'b0, m_q}) : t_r[tadm_pkg::MIX_W-1:0];
    sh_l_d  = {sh_l_q[tadm_pkg::QUO_W-2:0], ge_l};
    sh_r_d  = {sh_r_q[tadm_pkg::QUO_W-2:0], ge_r};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // Output register: filled on post, drained on accept
      if (post) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && cmd_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (valid_i) begin
            rem_l_q <= cmd_i.l_num[tadm_pkg::NUM_W-1:tadm_pkg::QUO_W];
            rem_r_q <= cmd_i.r_num[tadm_pkg::NUM_W-1:tadm_pkg::QUO_W];
            sh_l_q  <= cmd_i.l_num[tadm_pkg::QUO_W-1:0];
            sh_r_q  <= cmd_i.r_num[tadm_pkg::QUO_W-1:0];
            m_q     <= cmd_i.m;
            l_neg_q <= cmd_i.l_neg;
            r_neg_q <= cmd_i.r_neg;
            tr_q    <= cmd_i.trencher_rps;
            hb_q    <= cmd_i.hopper_belt_rps;
            ha_q    <= cmd_i.hopper_act_percent;
            dis_q   <= cmd_i.disabled;
            cnt_q   <= tadm_pkg::CNT_W'(tadm_pkg::DIV_STEPS);
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (cnt_q != '0) begin
            rem_l_q <= rem_l_d;
            rem_r_q <= rem_r_d;
            sh_l_q  <= sh_l_d;
            sh_r_q  <= sh_r_d;
            cnt_q   <= cnt_q - 1'b1;
          end else if (out_free) begin
            // Quotients done: apply signs and post the result
            lt_q        <= l_neg_q ? (tadm_pkg::RPS_W'(0) - {1'b0, sh_l_q}) : {1'b0, sh_l_q};
            rt_q        <= r_neg_q ? (tadm_pkg::RPS_W'(0) - {1'b0, sh_r_q}) : {1'b0, sh_r_q};
            otr_q       <= tr_q;
            ohb_q       <= hb_q;
            oha_q       <= ha_q;
            odis_q      <= dis_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign cmd_o.valid              = out_valid_q;
  assign cmd_o.left_track_rps     = lt_q;
  assign cmd_o.right_track_rps    = rt_q;
  assign cmd_o.trencher_rps       = otr_q;
  assign cmd_o.hopper_belt_rps    = ohb_q;
  assign cmd_o.hopper_act_percent = oha_q;
  assign cmd_o.disabled           = odis_q;

endmodule

// ----- hdl/teleop_arcade_drive_mixer.sv -----
`timescale 1ns / 1ps
// Channel   Dir  Handshake       Payload
// joy_i     in   valid/ready     stick axes, triggers, invert/speed/disable buttons
// cmd_o     out  valid/ready     track, trencher, belt velocities, actuator, disabled
// cfg       in   cfg_we_i        cfg_idx_i selects register, cfg_data_i 15 bits
//
// Each request passes through the back end as one load, 15 restoring-division
// steps (one quotient bit per cycle for both tracks) and a post of the result.
// The front end registers each request and can hold one while a two-entry queue
// holds two more, so input stalls only when all are full.
// A stalled output holds the finished result; the divider waits before posting.
// Reset is asynchronous, active low; config registers return to their defaults.

module teleop_arcade_drive_mixer (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tadm_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [tadm_pkg::REG_W-1:0]     cfg_data_i,
  tadm_in_if.sink                        joy_i,
  tadm_out_if.source                     cmd_o
);

  tadm_pkg::tadm_cfg_t cfg_q;
  tadm_pkg::tadm_cmd_t front_cmd, queue_cmd;
  logic                push, full, pop, queue_valid;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.drive_low_rps       <= tadm_pkg::RST_DRIVE_LOW;
      cfg_q.drive_med_rps       <= tadm_pkg::RST_DRIVE_MED;
      cfg_q.drive_high_rps      <= tadm_pkg::RST_DRIVE_HIGH;
      cfg_q.drive_deadzone      <= tadm_pkg::RST_DRIVE_DZ;
      cfg_q.stick_deadzone      <= tadm_pkg::RST_STICK_DZ;
      cfg_q.trencher_max_rps    <= tadm_pkg::RST_TRENCHER_MAX;
      cfg_q.hopper_belt_max_rps <= tadm_pkg::RST_HOPPER_MAX;
    end else if (cfg_we_i) begin
      case (tadm_pkg::cfg_idx_e'(cfg_idx_i))
        tadm_pkg::CFG_DRIVE_LOW:    cfg_q.drive_low_rps       <= cfg_data_i;
        tadm_pkg::CFG_DRIVE_MED:    cfg_q.drive_med_rps       <= cfg_data_i;
        tadm_pkg::CFG_DRIVE_HIGH:   cfg_q.drive_high_rps      <= cfg_data_i;
        tadm_pkg::CFG_DRIVE_DZ:     cfg_q.drive_deadzone      <= cfg_data_i;
        tadm_pkg::CFG_STICK_DZ:     cfg_q.stick_deadzone      <= cfg_data_i;
        tadm_pkg::CFG_TRENCHER_MAX: cfg_q.trencher_max_rps    <= cfg_data_i;
        tadm_pkg::CFG_HOPPER_MAX:   cfg_q.hopper_belt_max_rps <= cfg_data_i;
        default: ;
      endcase
    end
  end

  tadm_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .joy_i  (joy_i),
    .push_o (push),
    .cmd_o  (front_cmd),
    .full_i (full)
  );

  tadm_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (queue_valid),
    .data_o  (queue_cmd)
  );

  tadm_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (queue_valid),
    .cmd_i   (queue_cmd),
    .pop_o   (pop),
    .cmd_o   (cmd_o)
  );

endmodule
